[sv/cbis_pkg.sv]
// Shared constants and types for the CBOR item skipper.
package cbis_pkg;

    // Default stack depth and reset value of the nesting limit
    localparam int STACK_DEPTH_DEF = 8;
    localparam logic [2:0] MAX_NEST_RST = 3'd7;

    // Field widths
    localparam int COUNT_W = 64;
    localparam int BYTES_W = 32;
    localparam int NEST_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 40;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DONE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ERR  = 2'd2;

    // Major types
    localparam logic [2:0] MAJOR_BSTR   = 3'd2;
    localparam logic [2:0] MAJOR_TSTR   = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
    localparam logic [2:0] MAJOR_MAP    = 3'd5;
    localparam logic [2:0] MAJOR_TAG    = 3'd6;
    localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

    // Additional info boundaries
    localparam logic [4:0] INFO_ARG_FIRST = 5'd24;
    localparam logic [4:0] INFO_RESERVED  = 5'd28;

    // Decode phase of the byte stream
    typedef enum logic [1:0] {
        PH_HEAD,
        PH_ARG,
        PH_PAY
    } phase_t;

endpackage

[sv/cbor_item_skipper_top.sv]
// Top level of the CBOR item skipper: head decode, count stack and result register.
//
// Usage: encoded bytes enter on the s_axis channel, one byte per word; s_axis_tlast
// marks the last byte available in the buffer. Each accepted byte yields exactly
// one result word on m_axis: a status (busy, item complete, error), the number
// of bytes of the current item so far and the open container depth.
// A byte is taken and its result is registered at that same edge, so the result
// shows in the cycle after acceptance; a new byte is taken every cycle while the
// result register is free and no pop is running. A byte that closes containers
// walks the count stack down, one level per cycle, because each level's remaining
// count comes from the stack memory's registered read; no byte is taken meanwhile.
// After a completed item or an error all item state returns to its start and
// the next byte begins a new item; the nesting limit register is kept.
// cfg_we / cfg_wdata write the nesting limit; write it only while idle.
// Reset (rst_n low) clears the item state, sets the nesting limit to 7 and
// empties the result register; the stack memory needs no clearing.
// When the receiver stalls, the result register holds its word and s_axis_tready
// stays low, so no byte is taken until that word has been accepted.
module cbor_item_skipper_top
#(
    parameter int STACK_DEPTH = cbis_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration: nesting limit
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_wdata,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,   // end_of_buffer
    // Result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cbis_pkg::OUT_W-1:0]  m_axis_tdata    // [1:0] status, [33:2] item_bytes,
                                                        // [36:34] nesting_level, rest zero
);

    import cbis_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH);
    localparam int EXT_W = LVL_W + 3;

    typedef enum logic {
        S_RUN,
        S_POP
    } state_t;

    // Registers
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [LVL_W-1:0]     level_reg, level_next;
    logic [COUNT_W-1:0]   top_reg, top_next;
    logic [2:0]           head_major_reg, head_major_next;
    logic [COUNT_W-1:0]   arg_reg, arg_next;
    logic [3:0]           arg_left_reg, arg_left_next;
    logic [COUNT_W-1:0]   pay_reg, pay_next;
    logic [BYTES_W-1:0]   byte_count_reg, byte_count_next;
    logic                 eob_reg, eob_next;
    logic [2:0]           max_nest_reg, max_nest_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]    out_status_reg, out_status_next;
    logic [BYTES_W-1:0]   out_bytes_reg, out_bytes_next;
    logic [NEST_W-1:0]    out_nest_reg, out_nest_next;

    // Stack memory ports
    logic                 ram_we;
    logic [LVL_W-1:0]     ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [LVL_W-1:0]     ram_raddr;
    logic [COUNT_W-1:0]   ram_rdata;

    // Decode signals
    logic [2:0]           major;
    logic [4:0]           info;
    logic                 is_head, is_arg, is_pay;
    logic                 head_skip, head_resv, head_arg;
    logic                 arg_last, pay_last;
    logic [COUNT_W-1:0]   arg_shift;
    logic                 fin;
    logic [2:0]           fin_major;
    logic [COUNT_W-1:0]   fin_arg;
    logic                 fin_arg_zero;
    logic                 fin_str, fin_cont, fin_tag;
    logic [EXT_W-1:0]     nl_ext;
    logic                 cont_err, err, push;
    logic [COUNT_W-1:0]   push_count;
    phase_t               phase_after;
    logic                 top_is0, top_is1;
    logic [COUNT_W-1:0]   top_after;
    logic                 top_after_is0;
    logic                 check, pop_need, done;
    logic [BYTES_W-1:0]   bc_inc;
    logic                 accept, out_free, rd_is0;
    logic [EXT_W-1:0]     lvl_ext;
    logic [EXT_W-1:0]     nest_ext;

    cbis_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_RUN) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - NEST_W - BYTES_W - STAT_W){1'b0}},
                            out_nest_reg, out_bytes_reg, out_status_reg};

    // Split the byte and classify the head
    always_comb
    begin
        major     = s_axis_tdata[7:5];
        info      = s_axis_tdata[4:0];
        is_head   = (phase_reg == PH_HEAD);
        is_arg    = (phase_reg == PH_ARG);
        is_pay    = (phase_reg == PH_PAY);
        head_skip = is_head && (major == MAJOR_SIMPLE)
                    && (info >= INFO_ARG_FIRST) && (info < INFO_RESERVED);
        head_resv = is_head && (major != MAJOR_SIMPLE) && (info >= INFO_RESERVED);
        head_arg  = is_head && (major != MAJOR_SIMPLE)
                    && (info >= INFO_ARG_FIRST) && (info < INFO_RESERVED);
        arg_last  = (arg_left_reg <= 4'd1);
        pay_last  = (pay_reg[COUNT_W-1:1] == '0);
        arg_shift = {arg_reg[COUNT_W-9:0], s_axis_tdata};
    end

    // Finish a fully decoded head and derive the new top count
    always_comb
    begin
        fin          = (is_head && (major != MAJOR_SIMPLE) && (info < INFO_ARG_FIRST))
                       || (is_arg && arg_last);
        fin_major    = is_head ? major : head_major_reg;
        fin_arg      = is_head ? COUNT_W'(info) : arg_shift;
        fin_arg_zero = (fin_arg == '0);
        fin_str      = fin && ((fin_major == MAJOR_BSTR) || (fin_major == MAJOR_TSTR))
                       && !fin_arg_zero;
        fin_cont     = fin && ((fin_major == MAJOR_ARRAY) || (fin_major == MAJOR_MAP));
        fin_tag      = fin && (fin_major == MAJOR_TAG);

        // Nesting limit, stack depth and map count overflow
        nl_ext   = EXT_W'(level_reg) + EXT_W'(1);
        cont_err = fin_cont && ((nl_ext > EXT_W'(max_nest_reg))
                                || (nl_ext >= EXT_W'(STACK_DEPTH))
                                || ((fin_major == MAJOR_MAP) && fin_arg[COUNT_W-1]));
        err      = head_resv || cont_err;
        push     = fin_cont && !cont_err && !fin_arg_zero;
        push_count = (fin_major == MAJOR_MAP) ? {fin_arg[COUNT_W-2:0], 1'b0} : fin_arg;

        // Phase after this byte
        if (head_skip || fin_str || (is_pay && !pay_last))
        begin
            phase_after = PH_PAY;
        end
        else if (head_arg || (is_arg && !arg_last))
        begin
            phase_after = PH_ARG;
        end
        else
        begin
            phase_after = PH_HEAD;
        end

        // Count of the current level: a head uses one item, a tag adds one
        top_is0 = (top_reg == '0);
        top_is1 = (top_reg == COUNT_W'(1));
        if (is_head)
        begin
            if (fin_tag)
            begin
                top_after     = top_is0 ? COUNT_W'(1) : top_reg;
                top_after_is0 = 1'b0;
            end
            else
            begin
                top_after     = top_is0 ? '0 : top_reg - COUNT_W'(1);
                top_after_is0 = top_is0 || top_is1;
            end
        end
        else if (fin_tag)
        begin
            top_after     = top_reg + COUNT_W'(1);
            top_after_is0 = &top_reg;
        end
        else
        begin
            top_after     = top_reg;
            top_after_is0 = top_is0;
        end

        check    = !err && (phase_after == PH_HEAD) && !push;
        pop_need = check && top_after_is0 && (level_reg != '0);
        done     = check && top_after_is0 && (level_reg == '0);

        bc_inc   = (&byte_count_reg) ? byte_count_reg : byte_count_reg + BYTES_W'(1);
        rd_is0   = (ram_rdata == '0);
        lvl_ext  = EXT_W'(level_reg);
        nest_ext = push ? nl_ext : lvl_ext;
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        level_next      = level_reg;
        top_next        = top_reg;
        head_major_next = head_major_reg;
        arg_next        = arg_reg;
        arg_left_next   = arg_left_reg;
        pay_next        = pay_reg;
        byte_count_next = byte_count_reg;
        eob_next        = eob_reg;
        max_nest_next   = cfg_we ? cfg_wdata : max_nest_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_bytes_next  = out_bytes_reg;
        out_nest_next   = out_nest_reg;
        ram_we          = 1'b0;
        ram_waddr       = level_reg;
        ram_wdata       = top_after;
        ram_re          = 1'b0;
        ram_raddr       = LVL_W'(level_reg - LVL_W'(1));

        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    byte_count_next = bc_inc;
                    phase_next      = phase_after;

                    // Argument bytes
                    if (head_arg)
                    begin
                        head_major_next = major;
                        arg_next        = '0;
                        arg_left_next   = 4'(4'd1 << info[1:0]);
                    end
                    else if (is_arg)
                    begin
                        arg_next      = arg_shift;
                        arg_left_next = (arg_left_reg != 4'd0) ? arg_left_reg - 4'd1 : 4'd0;
                    end

                    // Payload bytes
                    if (head_skip)
                    begin
                        pay_next = COUNT_W'(1) << info[1:0];
                    end
                    else if (fin_str)
                    begin
                        pay_next = fin_arg;
                    end
                    else if (is_pay)
                    begin
                        pay_next = (pay_reg != '0) ? pay_reg - COUNT_W'(1) : '0;
                    end

                    // Push a new container level, or update the current one
                    if (push)
                    begin
                        ram_we     = 1'b1;
                        top_next   = push_count;
                        level_next = nl_ext[LVL_W-1:0];
                    end
                    else
                    begin
                        top_next = top_after;
                    end

                    if (pop_need)
                    begin
                        // Close this level and fetch the parent count
                        ram_re     = 1'b1;
                        level_next = LVL_W'(level_reg - LVL_W'(1));
                        eob_next   = s_axis_tlast;
                        state_next = S_POP;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_bytes_next  = bc_inc;
                        out_nest_next   = nest_ext[NEST_W-1:0];
                        if (err || (!done && s_axis_tlast))
                        begin
                            out_status_next = STATUS_ERR;
                        end
                        else if (done)
                        begin
                            out_status_next = STATUS_DONE;
                        end
                        else
                        begin
                            out_status_next = STATUS_BUSY;
                        end
                        if (err || done || s_axis_tlast)
                        begin
                            phase_next      = PH_HEAD;
                            level_next      = '0;
                            top_next        = COUNT_W'(1);
                            head_major_next = '0;
                            arg_next        = '0;
                            arg_left_next   = '0;
                            pay_next        = '0;
                            byte_count_next = '0;
                        end
                    end
                end
            end

            S_POP:
            begin
                if (rd_is0 && (level_reg != '0))
                begin
                    // Parent is exhausted too: keep walking down
                    ram_re     = 1'b1;
                    level_next = LVL_W'(level_reg - LVL_W'(1));
                end
                else if (out_free)
                begin
                    top_next        = ram_rdata;
                    out_valid_next  = 1'b1;
                    out_bytes_next  = byte_count_reg;
                    out_nest_next   = lvl_ext[NEST_W-1:0];
                    state_next      = S_RUN;
                    if (rd_is0)
                    begin
                        out_status_next = STATUS_DONE;
                    end
                    else if (eob_reg)
                    begin
                        out_status_next = STATUS_ERR;
                    end
                    else
                    begin
                        out_status_next = STATUS_BUSY;
                    end
                    if (rd_is0 || eob_reg)
                    begin
                        phase_next      = PH_HEAD;
                        level_next      = '0;
                        top_next        = COUNT_W'(1);
                        head_major_next = '0;
                        arg_next        = '0;
                        arg_left_next   = '0;
                        pay_next        = '0;
                        byte_count_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            phase_reg      <= PH_HEAD;
            level_reg      <= '0;
            top_reg        <= COUNT_W'(1);
            head_major_reg <= '0;
            arg_reg        <= '0;
            arg_left_reg   <= '0;
            pay_reg        <= '0;
            byte_count_reg <= '0;
            eob_reg        <= 1'b0;
            max_nest_reg   <= MAX_NEST_RST;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_BUSY;
            out_bytes_reg  <= '0;
            out_nest_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            top_reg        <= top_next;
            head_major_reg <= head_major_next;
            arg_reg        <= arg_next;
            arg_left_reg   <= arg_left_next;
            pay_reg        <= pay_next;
            byte_count_reg <= byte_count_next;
            eob_reg        <= eob_next;
            max_nest_reg   <= max_nest_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_bytes_reg  <= out_bytes_next;
            out_nest_reg   <= out_nest_next;
        end
    end

endmodule

[sv/cbis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cbis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[tb/cbor_item_skipper_top_tb.sv]
// Testbench for the CBOR item skipper: streams directed, well-formed, broken and noise bytes and checks every result word.
module cbor_item_skipper_top_tb;

    import cbis_pkg::*;

    localparam int NEST_SLOTS  = STACK_DEPTH_DEF;
    localparam int BYTES_LSB   = STAT_W;
    localparam int NEST_LSB    = STAT_W + BYTES_W;
    localparam int PAD_LSB     = NEST_LSB + NEST_W;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_END  = 950;
    localparam int TOTAL_BYTES = 1050;

    // Major types the package leaves out
    localparam logic [2:0] MAJOR_UINT = 3'd0;
    localparam logic [2:0] MAJOR_NINT = 3'd1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [BYTES_W-1:0] item_bytes;
        logic [NEST_W-1:0]  nest;
    } byte_status_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;    // [7:0] data_byte
    logic              s_axis_tlast;    // end_of_buffer
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;    // [1:0] status, [33:2] item_bytes, [36:34] nesting_level

    // Predicted skipper state
    logic [COUNT_W-1:0] left_cnt [NEST_SLOTS];
    int unsigned        open_lvl;
    phase_t             ph;
    logic [2:0]         arg_major;
    logic [63:0]        arg_val;
    int unsigned        arg_left;
    logic [63:0]        pay_left;
    logic [BYTES_W-1:0] byte_cnt;
    logic [2:0]         nest_limit;

    byte_status_t byte_status_q[$];
    logic [7:0]   frame_q[$];

    bit          idle_on = 1'b1;
    int unsigned sink_hold = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count = 0;

    cbor_item_skipper_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return all item state to the start of a new item
    function automatic void restart_item();
        int unsigned i;
        for (i = 0; i < NEST_SLOTS; i++)
            left_cnt[i] = '0;
        left_cnt[0] = 64'd1;
        open_lvl  = 0;
        ph        = PH_HEAD;
        arg_major = '0;
        arg_val   = '0;
        arg_left  = 0;
        pay_left  = '0;
        byte_cnt  = '0;
    endfunction

    // Act on a fully decoded head; return 1 on error
    function automatic logic apply_head(input logic [2:0] major, input logic [63:0] arg);
        int unsigned nl;
        logic [63:0] n;
        nl = open_lvl + 1;
        n  = arg;
        if (major == MAJOR_BSTR || major == MAJOR_TSTR)
        begin
            if (arg != 0)
            begin
                pay_left = arg;
                ph = PH_PAY;
            end
        end
        else if (major == MAJOR_ARRAY || major == MAJOR_MAP)
        begin
            if (nl > nest_limit || nl >= NEST_SLOTS)
                return 1'b1;
            // maps count key and value separately
            if (major == MAJOR_MAP)
            begin
                if (arg[63])
                    return 1'b1;
                n = arg << 1;
            end
            open_lvl = nl;
            left_cnt[nl] = n;
        end
        else if (major == MAJOR_TAG)
        begin
            left_cnt[open_lvl] = left_cnt[open_lvl] + 64'd1;
        end
        return 1'b0;
    endfunction

    // Advance the predicted state by one accepted byte and queue its result word
    function automatic void track_byte(input logic [7:0] b, input logic eob);
        logic [2:0]   major;
        logic [4:0]   info;
        logic         err;
        logic         done;
        byte_status_t r;
        major = b[7:5];
        info  = b[4:0];
        err   = 1'b0;
        done  = 1'b0;
        if (byte_cnt != '1)
            byte_cnt = byte_cnt + 1'b1;

        case (ph)
            PH_ARG:
            begin
                arg_val = {arg_val[55:0], b};
                if (arg_left > 0)
                    arg_left--;
                if (arg_left == 0)
                begin
                    ph = PH_HEAD;
                    err = apply_head(arg_major, arg_val);
                end
            end
            PH_PAY:
            begin
                if (pay_left != 0)
                    pay_left = pay_left - 64'd1;
                if (pay_left == 0)
                    ph = PH_HEAD;
            end
            default:
            begin
                ph = PH_HEAD;
                if (left_cnt[open_lvl] != 0)
                    left_cnt[open_lvl] = left_cnt[open_lvl] - 64'd1;
                if (major == MAJOR_SIMPLE)
                begin
                    // simple values with info 24..27 skip 1, 2, 4 or 8 bytes
                    if (info >= INFO_ARG_FIRST && info < INFO_RESERVED)
                    begin
                        pay_left = 64'd1 << (info - INFO_ARG_FIRST);
                        ph = PH_PAY;
                    end
                end
                else if (info >= INFO_RESERVED)
                begin
                    err = 1'b1;
                end
                else if (info >= INFO_ARG_FIRST)
                begin
                    arg_major = major;
                    arg_val   = '0;
                    arg_left  = 1 << (info - INFO_ARG_FIRST);
                    ph        = PH_ARG;
                end
                else
                begin
                    err = apply_head(major, {59'd0, info});
                end
            end
        endcase

        // Close every finished container
        if (!err && ph == PH_HEAD)
        begin
            while (open_lvl > 0 && left_cnt[open_lvl] == 0)
                open_lvl--;
            if (open_lvl == 0 && left_cnt[0] == 0)
                done = 1'b1;
        end

        r.status     = err ? STATUS_ERR : (done ? STATUS_DONE : (eob ? STATUS_ERR : STATUS_BUSY));
        r.item_bytes = byte_cnt;
        r.nest       = 3'(open_lvl);
        byte_status_q.push_back(r);
        if (r.status != STATUS_BUSY)
            restart_item();
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    function automatic logic [7:0] hd(input logic [2:0] major, input logic [4:0] info);
        return {major, info};
    endfunction

    // Argument of varied magnitude
    function automatic logic [63:0] pick_arg();
        case ($urandom_range(0, 4))
            0:       return 64'($urandom_range(0, 23));
            1:       return 64'($urandom_range(0, 255));
            2:       return 64'($urandom_range(0, 65535));
            3:       return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Append a head, sometimes with a wider argument than needed
    function automatic void put_head(input logic [2:0] major, input logic [63:0] val);
        int unsigned w;
        int i;
        if (val < 24 && $urandom_range(0, 2) != 0)
        begin
            frame_q.push_back(hd(major, val[4:0]));
            return;
        end
        w = (val < 64'h100) ? 0 : (val < 64'h1_0000) ? 1 : (val < 64'h1_0000_0000) ? 2 : 3;
        if (w < 3 && $urandom_range(0, 3) == 0)
            w = $urandom_range(w, 3);
        frame_q.push_back(hd(major, INFO_ARG_FIRST + 5'(w)));
        for (i = (1 << w) - 1; i >= 0; i--)
            frame_q.push_back(val[i*8 +: 8]);
    endfunction

    // Append one well-formed item; the queue holds the items still owed per open level
    function automatic void build_item();
        int unsigned need[$];
        int unsigned kind;
        int unsigned cnt;
        int unsigned lvl;
        int unsigned len;
        int unsigned nb;
        int unsigned sel;
        need.push_back(1);
        while (need.size() != 0)
        begin
            if (need[$] == 0)
            begin
                void'(need.pop_back());
                continue;
            end
            need[$] = need[$] - 1;
            lvl  = need.size() - 1;
            kind = $urandom_range(0, 9);
            if (lvl >= 9 && kind >= 4 && kind <= 6)
                kind = 0;
            case (kind)
                0, 1:
                begin
                    put_head((kind == 0) ? MAJOR_UINT : MAJOR_NINT, pick_arg());
                end
                2, 3:
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
                    put_head((kind == 2) ? MAJOR_BSTR : MAJOR_TSTR, 64'(len));
                    repeat (len) frame_q.push_back(8'($urandom));
                end
                4, 5:
                begin
                    cnt = $urandom_range(0, (lvl < 2) ? 3 : 1);
                    put_head(MAJOR_ARRAY, 64'(cnt));
                    need.push_back(cnt);
                end
                6:
                begin
                    cnt = $urandom_range(0, (lvl < 2) ? 2 : 1);
                    put_head(MAJOR_MAP, 64'(cnt));
                    need.push_back(2 * cnt);
                end
                7:
                begin
                    put_head(MAJOR_TAG, pick_arg());
                    need[$] = need[$] + 1;
                end
                default:
                begin
                    sel = $urandom_range(0, 3);
                    if (sel < 2)
                    begin
                        frame_q.push_back(hd(MAJOR_SIMPLE, 5'($urandom_range(0, 23))));
                    end
                    else if (sel == 2)
                    begin
                        nb = $urandom_range(0, 3);
                        frame_q.push_back(hd(MAJOR_SIMPLE, INFO_ARG_FIRST + 5'(nb)));
                        repeat (1 << nb) frame_q.push_back(8'($urandom));
                    end
                    else
                    begin
                        frame_q.push_back(hd(MAJOR_SIMPLE, INFO_RESERVED + 5'($urandom_range(0, 3))));
                    end
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte, wait for the handshake, then predict its result
    task automatic send_byte(input logic [7:0] b, input logic eob);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_byte(b, eob);
        bytes_sent++;
    endtask

    // Send the built frame; mark its last byte, and with stray set mark a few others
    task automatic send_frame(input bit mark_end, input bit stray);
        int unsigned i;
        logic eob;
        for (i = 0; i < frame_q.size(); i++)
        begin
            eob = (mark_end && i == frame_q.size() - 1) || (stray && $urandom_range(0, 63) == 0);
            send_byte(frame_q[i], eob);
        end
        frame_q.delete();
    endtask

    // Build and send one frame of random shape
    task automatic send_random_frame();
        int unsigned kind;
        int unsigned cut;
        frame_q.delete();
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            // well-formed items back to back
            repeat ($urandom_range(1, 3)) build_item();
        end
        else if (kind == 6)
        begin
            // truncated item
            build_item();
            if (frame_q.size() > 1)
            begin
                cut = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
        else if (kind == 7)
        begin
            // noise
            repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
        end
        else if (kind == 8)
        begin
            // reserved info on a head inside an array
            frame_q.push_back(hd(MAJOR_ARRAY, 5'd2));
            build_item();
            frame_q.push_back(hd(3'($urandom_range(0, 6)), INFO_RESERVED + 5'($urandom_range(0, 3))));
        end
        else
        begin
            // container with a large count, possibly a map that overflows
            put_head(($urandom_range(0, 1) == 0) ? MAJOR_ARRAY : MAJOR_MAP, pick_arg());
            repeat ($urandom_range(1, 2)) build_item();
        end
        send_frame(1'b1, 1'b1);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (byte_status_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the nesting limit while the block is idle
    task automatic write_nest_limit(input logic [2:0] v);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        nest_limit = v;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH word %0d %s: got %0h expected %0h", results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(input logic [OUT_W-1:0] word);
        byte_status_t want;
        results_seen++;
        if (byte_status_q.size() == 0)
        begin
            note_mismatch("unexpected word", 64'(word), 64'd0);
            return;
        end
        want = byte_status_q.pop_front();
        if (word[BYTES_LSB-1:0] != want.status)
            note_mismatch("status", 64'(word[BYTES_LSB-1:0]), 64'(want.status));
        if (word[NEST_LSB-1:BYTES_LSB] != want.item_bytes)
            note_mismatch("item_bytes", 64'(word[NEST_LSB-1:BYTES_LSB]), 64'(want.item_bytes));
        if (word[PAD_LSB-1:NEST_LSB] != want.nest)
            note_mismatch("nesting_level", 64'(word[PAD_LSB-1:NEST_LSB]), 64'(want.nest));
        if (word[OUT_W-1:PAD_LSB] != '0)
            note_mismatch("padding", 64'(word[OUT_W-1:PAD_LSB]), 64'd0);
    endtask

    // Take result words, with random stalls and a long hold on request
    initial
    begin : result_sink
        int unsigned gap;
        gap = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                gap = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // End the run when no word moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every major type and the special cases, one at a time
    task automatic test_directed();
        // smallest and largest direct integers, no end mark
        frame_q = '{hd(MAJOR_UINT, 5'd0)};
        send_frame(1'b0, 1'b0);
        frame_q = '{hd(MAJOR_NINT, 5'd23)};
        send_frame(1'b0, 1'b0);
        // reserved info on an integer errs
        frame_q = '{hd(MAJOR_UINT, INFO_RESERVED)};
        send_frame(1'b0, 1'b0);
        // reserved info on a simple value is a plain value; all-ones byte with end mark
        frame_q = '{hd(MAJOR_SIMPLE, 5'd31)};
        send_frame(1'b1, 1'b0);
        // tag owes one more item
        frame_q = '{hd(MAJOR_TAG, 5'd1), hd(MAJOR_UINT, 5'd0)};
        send_frame(1'b0, 1'b0);
        // empty array, empty map, empty text
        frame_q = '{hd(MAJOR_ARRAY, 5'd0), hd(MAJOR_MAP, 5'd0), hd(MAJOR_TSTR, 5'd0)};
        send_frame(1'b0, 1'b0);
        // map whose entry count reaches the top bit
        frame_q = '{hd(MAJOR_MAP, INFO_ARG_FIRST + 5'd3), 8'h80,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(1'b0, 1'b0);
        // buffer ends inside an array
        frame_q = '{hd(MAJOR_ARRAY, 5'd2), hd(MAJOR_UINT, 5'd1)};
        send_frame(1'b1, 1'b0);
        // simple value with one extra byte, then a one-byte string
        frame_q = '{hd(MAJOR_SIMPLE, INFO_ARG_FIRST), 8'h20, hd(MAJOR_BSTR, 5'd1), 8'h00};
        send_frame(1'b0, 1'b0);
    endtask

    // Each nesting limit, extremes first, at and just past the boundary
    task automatic test_nest_limits();
        logic [2:0] limits[7] = '{3'd1, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
        int unsigned k;
        int unsigned stop_at;
        for (k = 0; k < 7; k++)
        begin
            write_nest_limit(limits[k]);
            // deepest accepted nesting completes
            repeat (limits[k]) frame_q.push_back(hd(MAJOR_ARRAY, 5'd1));
            frame_q.push_back(hd(MAJOR_UINT, 5'd7));
            send_frame(1'b0, 1'b0);
            // one level deeper errs, even for an empty map
            repeat (limits[k]) frame_q.push_back(hd(MAJOR_ARRAY, 5'd1));
            frame_q.push_back(hd(MAJOR_MAP, 5'd0));
            send_frame(1'b0, 1'b0);
            stop_at = bytes_sent + 25;
            while (bytes_sent < stop_at)
                send_random_frame();
        end
    endtask

    // Hold the result side off while the sender keeps offering bytes
    task automatic test_receiver_hold();
        int unsigned stop_at;
        sink_hold = LONG_HOLD;
        stop_at = bytes_sent + 40;
        while (bytes_sent < stop_at)
            send_random_frame();
    endtask

    // Pause the sender until every result has come back, a few times
    task automatic test_sender_pause();
        int unsigned stop_at;
        repeat (3)
        begin
            stop_at = bytes_sent + 15;
            while (bytes_sent < stop_at)
                send_random_frame();
            drain_results();
        end
    endtask

    // Bulk random frames with occasional limit changes
    task automatic test_random_traffic();
        int unsigned next_cfg;
        next_cfg = bytes_sent + 150;
        while (bytes_sent < RANDOM_END)
        begin
            send_random_frame();
            if (bytes_sent >= next_cfg)
            begin
                write_nest_limit(3'($urandom_range(1, 7)));
                next_cfg = bytes_sent + 150;
            end
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_full_rate();
        write_nest_limit(MAX_NEST_RST);
        idle_on = 1'b0;
        while (bytes_sent < TOTAL_BYTES)
            send_random_frame();
    endtask

    initial
    begin : main
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        restart_item();
        nest_limit = MAX_NEST_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_nest_limits();
        test_receiver_hold();
        test_sender_pause();
        test_random_traffic();
        test_full_rate();

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
